// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising clk edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/issu_pkg.sv
// ---------------------------------------------------------------------------
// issu_pkg
// Types, codes and character constants of the source scanner.
// ---------------------------------------------------------------------------
package issu_pkg;

  // width of the saturating line counter
  localparam int LINE_BITS = 24;
  // fixed widths of the transaction fields
  localparam int BYTE_BITS = 8;
  localparam int ERR_BITS  = 3;
  localparam int LNUM_BITS = 24;

  typedef logic [LINE_BITS-1:0] line_t;
  typedef logic [BYTE_BITS-1:0] byte_t;

  // scanner mode
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_STRING  = 3'd1,
    MODE_ESCAPE  = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_DASH    = 3'd4,
    MODE_SLASH   = 3'd5,
    MODE_NUMBER  = 3'd6,
    MODE_HALTED  = 3'd7
  } mode_t;

  // error codes reported in error_kind
  typedef enum logic [ERR_BITS-1:0] {
    ERR_NONE    = 3'd0,
    ERR_UNTERM  = 3'd1,
    ERR_SLASH   = 3'd2,
    ERR_CARET   = 3'd3,
    ERR_FLOAT   = 3'd4
  } err_t;

  // result transaction
  typedef struct packed {
    logic [ERR_BITS-1:0]  error_kind;
    logic [LNUM_BITS-1:0] line_number;
  } out_item_t;

  // characters the scanner reacts to
  localparam byte_t CH_CARET  = 8'h5E;
  localparam byte_t CH_SLASH  = 8'h2F;
  localparam byte_t CH_DASH   = 8'h2D;
  localparam byte_t CH_DOT    = 8'h2E;
  localparam byte_t CH_NL     = 8'h0A;
  localparam byte_t CH_SQUOTE = 8'h27;
  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_UNDER  = 8'h5F;

endpackage

// File: rtl/issu_in_if.sv
// ---------------------------------------------------------------------------
// issu_in_if
// Source byte channel: valid/ready handshake with one byte per transaction.
// ---------------------------------------------------------------------------
interface issu_in_if;
  logic                            valid;
  logic                            ready;
  logic [issu_pkg::BYTE_BITS-1:0]  source_byte;
  logic                            end_of_source;

  modport source (output valid, output source_byte, output end_of_source, input ready);
  modport sink   (input valid, input source_byte, input end_of_source, output ready);
endinterface

// File: rtl/issu_out_if.sv
// ---------------------------------------------------------------------------
// issu_out_if
// Result channel: valid/ready handshake with error code and line number.
// ---------------------------------------------------------------------------
interface issu_out_if;
  logic                            valid;
  logic                            ready;
  logic [issu_pkg::ERR_BITS-1:0]   error_kind;
  logic [issu_pkg::LNUM_BITS-1:0]  line_number;

  modport source (output valid, output error_kind, output line_number, input ready);
  modport sink   (input valid, input error_kind, input line_number, output ready);
endinterface

// File: rtl/integer_subset_source_scanner_unit.sv
// ---------------------------------------------------------------------------
// integer_subset_source_scanner_unit
// Byte-serial scanner that counts lines and flags strings left open, lone
// slashes, carets and float literals in script source.
//
// One source byte is taken per clock cycle while in_ready is high. Each
// byte updates the mode register and the saturating line counter, and a
// result (on an error or on the byte marked end_of_source) is written into
// a two-entry output buffer. in_ready stays high while the second buffer
// entry is free, so bytes keep flowing while a result waits on a stalled
// output; only two unread results stop the input. After an error, bytes
// are dropped without a result up to and including the end_of_source byte,
// which returns the scanner to its reset state for the next source.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_subset_source_scanner_unit (
  input  logic        clk,
  input  logic        rst_n,
  issu_in_if.sink     in_ch,
  issu_out_if.source  out_ch
);

  // scanner state
  issu_pkg::mode_t     mode_r, mode_nxt;
  logic                quote_r, quote_nxt;
  issu_pkg::line_t     line_cnt_r, line_upd;

  // output buffer
  logic                out_valid_r, skid_valid_r;
  issu_pkg::out_item_t out_r, skid_r;

  // per-byte combinational results
  issu_pkg::err_t      err;
  logic                bump;
  logic                plain;
  logic                produce;
  logic                accept;
  logic                push;
  logic                pop;
  issu_pkg::out_item_t res;
  issu_pkg::byte_t     c;
  logic                last;

  // character classes
  function automatic logic is_digit(input issu_pkg::byte_t b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_run_byte(input issu_pkg::byte_t b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h41) && (b <= 8'h5A)) ||
           (b == issu_pkg::CH_DOT) || (b == issu_pkg::CH_UNDER);
  endfunction

  function automatic logic is_float_mark(input issu_pkg::byte_t b);
    return (b == issu_pkg::CH_DOT) || (b == 8'h65) || (b == 8'h45) ||
           (b == 8'h70) || (b == 8'h50);
  endfunction

  assign c    = in_ch.source_byte;
  assign last = in_ch.end_of_source;

  // handshake
  assign in_ch.ready = rst_n && !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_valid_r && out_ch.ready;
  assign push        = accept && produce;

  // next mode and error for the current byte
  always_comb begin
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    bump      = 1'b0;
    err       = issu_pkg::ERR_NONE;
    plain     = 1'b0;
    case (mode_r)
      issu_pkg::MODE_HALTED: begin
        mode_nxt = issu_pkg::MODE_HALTED;
      end
      issu_pkg::MODE_STRING: begin
        if (c == (quote_r ? issu_pkg::CH_DQUOTE : issu_pkg::CH_SQUOTE)) begin
          mode_nxt = issu_pkg::MODE_NORMAL;
        end else if (c == issu_pkg::CH_BSLASH) begin
          mode_nxt = issu_pkg::MODE_ESCAPE;
        end else if (c == issu_pkg::CH_NL) begin
          bump = 1'b1;
        end
      end
      issu_pkg::MODE_ESCAPE: begin
        mode_nxt = issu_pkg::MODE_STRING;
      end
      issu_pkg::MODE_COMMENT: begin
        if (c == issu_pkg::CH_NL) begin
          bump     = 1'b1;
          mode_nxt = issu_pkg::MODE_NORMAL;
        end
      end
      issu_pkg::MODE_DASH: begin
        if (c == issu_pkg::CH_DASH) begin
          mode_nxt = issu_pkg::MODE_COMMENT;
        end else begin
          plain = 1'b1;
        end
      end
      issu_pkg::MODE_SLASH: begin
        if (c == issu_pkg::CH_SLASH) begin
          mode_nxt = issu_pkg::MODE_NORMAL;
        end else begin
          err = issu_pkg::ERR_SLASH;
        end
      end
      issu_pkg::MODE_NUMBER: begin
        if (is_run_byte(c)) begin
          if (is_float_mark(c)) begin
            err = issu_pkg::ERR_FLOAT;
          end
        end else begin
          plain = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    // byte seen as ordinary text
    if (plain) begin
      mode_nxt = issu_pkg::MODE_NORMAL;
      if (c == issu_pkg::CH_NL) begin
        bump = 1'b1;
      end else if ((c == issu_pkg::CH_SQUOTE) || (c == issu_pkg::CH_DQUOTE)) begin
        quote_nxt = (c == issu_pkg::CH_DQUOTE);
        mode_nxt  = issu_pkg::MODE_STRING;
      end else if (c == issu_pkg::CH_DASH) begin
        mode_nxt = issu_pkg::MODE_DASH;
      end else if (c == issu_pkg::CH_SLASH) begin
        mode_nxt = issu_pkg::MODE_SLASH;
      end else if (c == issu_pkg::CH_CARET) begin
        err = issu_pkg::ERR_CARET;
      end else if (is_digit(c)) begin
        mode_nxt = issu_pkg::MODE_NUMBER;
      end
    end

    // checks on the final byte
    if ((err == issu_pkg::ERR_NONE) && last) begin
      if ((mode_nxt == issu_pkg::MODE_STRING) || (mode_nxt == issu_pkg::MODE_ESCAPE)) begin
        err = issu_pkg::ERR_UNTERM;
      end else if (mode_nxt == issu_pkg::MODE_SLASH) begin
        err = issu_pkg::ERR_SLASH;
      end
    end
  end

  // saturating line count and result word
  always_comb begin
    line_upd = line_cnt_r;
    if (bump && (line_cnt_r != '1)) begin
      line_upd = line_cnt_r + issu_pkg::line_t'(1);
    end
    produce         = (mode_r != issu_pkg::MODE_HALTED) &&
                      ((err != issu_pkg::ERR_NONE) || last);
    res.error_kind  = err;
    res.line_number = issu_pkg::LNUM_BITS'(line_upd);
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= issu_pkg::MODE_NORMAL;
      quote_r    <= 1'b0;
      line_cnt_r <= issu_pkg::line_t'(1);
    end else if (accept) begin
      if (last) begin
        mode_r     <= issu_pkg::MODE_NORMAL;
        quote_r    <= 1'b0;
        line_cnt_r <= issu_pkg::line_t'(1);
      end else begin
        mode_r     <= produce ? issu_pkg::MODE_HALTED : mode_nxt;
        quote_r    <= quote_nxt;
        line_cnt_r <= line_upd;
      end
    end
  end

  // two-entry output buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.error_kind  = out_r.error_kind;
  assign out_ch.line_number = out_r.line_number;

  // checks
  `ASSERT_ALWAYS(a_skid_needs_out, !rst_n || !skid_valid_r || out_valid_r,
                 "skid entry without head entry")
  `ASSERT_CLK(a_halted_silent, (accept && (mode_r == issu_pkg::MODE_HALTED)) |-> !push,
              "result while halted")
  `ASSERT_CLK(a_last_resets, (accept && last) |=> ((mode_r == issu_pkg::MODE_NORMAL) &&
              (line_cnt_r == issu_pkg::line_t'(1))), "end of source did not reset scanner")
  `ASSERT_CLK(a_line_nonzero, line_cnt_r != '0, "line counter wrapped to zero")
  `ASSERT_CLK(a_no_push_when_full, skid_valid_r |-> !push, "result pushed into full buffer")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench for integer_subset_source_scanner_unit
// Sends script source byte by byte and keeps its own scanner model. Every
// result transaction is checked against that model: the error code and the
// line number. Directed sources hit each error kind, open strings at the end
// of a source and clean ends, then random token streams run with and without
// handshake gaps, and one phase holds the output off long enough for the input to stall.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 150;

  logic clk;
  logic rst_n;

  issu_in_if  in_ch();
  issu_out_if out_ch();

  integer_subset_source_scanner_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // scanner model state
  issu_pkg::mode_t scan_state;
  logic            in_dq_string;
  issu_pkg::line_t line_ctr;

  issu_pkg::out_item_t expected_results[$];

  int fail_count;
  int sources_sent;
  int live_bytes;
  int dropped_bytes;
  int kind_count[5];
  int input_stall_cycles;
  int cycle_count;
  bit gaps_on;
  bit hold_req;
  int hold_left;
  int held_cycles;

  // ---------------------------------------------------------------------------
  // scanner model
  // ---------------------------------------------------------------------------
  function automatic void reset_scanner();
    scan_state   = issu_pkg::MODE_NORMAL;
    in_dq_string = 1'b0;
    line_ctr     = issu_pkg::line_t'(1);
  endfunction

  // saturating line count
  function automatic void count_line();
    if (line_ctr != '1) line_ctr = line_ctr + issu_pkg::line_t'(1);
  endfunction

  function automatic bit is_digit_ch(issu_pkg::byte_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_run_byte(issu_pkg::byte_t c);
    return is_digit_ch(c) || ((c >= "a") && (c <= "z")) ||
           ((c >= "A") && (c <= "Z")) ||
           (c == issu_pkg::CH_DOT) || (c == issu_pkg::CH_UNDER);
  endfunction

  function automatic bit is_float_mark(issu_pkg::byte_t c);
    return (c == issu_pkg::CH_DOT) || (c == "e") || (c == "E") || (c == "p") || (c == "P");
  endfunction

  // byte seen in normal mode
  function automatic issu_pkg::err_t plain_byte(issu_pkg::byte_t c);
    scan_state = issu_pkg::MODE_NORMAL;
    if (c == issu_pkg::CH_NL) begin
      count_line();
    end else if ((c == issu_pkg::CH_SQUOTE) || (c == issu_pkg::CH_DQUOTE)) begin
      in_dq_string = (c == issu_pkg::CH_DQUOTE);
      scan_state   = issu_pkg::MODE_STRING;
    end else if (c == issu_pkg::CH_DASH) begin
      scan_state = issu_pkg::MODE_DASH;
    end else if (c == issu_pkg::CH_SLASH) begin
      scan_state = issu_pkg::MODE_SLASH;
    end else if (c == issu_pkg::CH_CARET) begin
      return issu_pkg::ERR_CARET;
    end else if (is_digit_ch(c)) begin
      scan_state = issu_pkg::MODE_NUMBER;
    end
    return issu_pkg::ERR_NONE;
  endfunction

  // advance the model by one accepted byte, queue any result it raises
  task automatic predict_scan(input issu_pkg::byte_t c, input bit last);
    issu_pkg::err_t      err;
    issu_pkg::out_item_t res;
    err = issu_pkg::ERR_NONE;
    // after an error, bytes are dropped up to the end of the source
    if (scan_state == issu_pkg::MODE_HALTED) begin
      dropped_bytes++;
      if (last) reset_scanner();
      return;
    end
    live_bytes++;
    case (scan_state)
      issu_pkg::MODE_STRING: begin
        if (c == (in_dq_string ? issu_pkg::CH_DQUOTE : issu_pkg::CH_SQUOTE))
          scan_state = issu_pkg::MODE_NORMAL;
        else if (c == issu_pkg::CH_BSLASH) scan_state = issu_pkg::MODE_ESCAPE;
        else if (c == issu_pkg::CH_NL) count_line();
      end
      issu_pkg::MODE_ESCAPE: scan_state = issu_pkg::MODE_STRING;
      issu_pkg::MODE_COMMENT: begin
        if (c == issu_pkg::CH_NL) begin
          count_line();
          scan_state = issu_pkg::MODE_NORMAL;
        end
      end
      issu_pkg::MODE_DASH: begin
        if (c == issu_pkg::CH_DASH) scan_state = issu_pkg::MODE_COMMENT;
        else err = plain_byte(c);
      end
      issu_pkg::MODE_SLASH: begin
        if (c == issu_pkg::CH_SLASH) scan_state = issu_pkg::MODE_NORMAL;
        else err = issu_pkg::ERR_SLASH;
      end
      issu_pkg::MODE_NUMBER: begin
        if (is_run_byte(c)) begin
          if (is_float_mark(c)) err = issu_pkg::ERR_FLOAT;
        end else begin
          err = plain_byte(c);
        end
      end
      default: err = plain_byte(c);
    endcase
    // open string or pending slash at the final byte
    if ((err == issu_pkg::ERR_NONE) && last) begin
      if ((scan_state == issu_pkg::MODE_STRING) || (scan_state == issu_pkg::MODE_ESCAPE))
        err = issu_pkg::ERR_UNTERM;
      else if (scan_state == issu_pkg::MODE_SLASH) err = issu_pkg::ERR_SLASH;
    end
    if ((err != issu_pkg::ERR_NONE) || last) begin
      res.error_kind  = err;
      res.line_number = line_ctr[issu_pkg::LNUM_BITS-1:0];
      expected_results.push_back(res);
      kind_count[err]++;
      if (last) reset_scanner();
      else scan_state = issu_pkg::MODE_HALTED;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_byte(input issu_pkg::byte_t b, input bit last);
    while (gaps_on && ($urandom_range(0, 99) < 7)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.source_byte   <= b;
    in_ch.end_of_source <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_scan(b, last);
  endtask

  task automatic send_source(input issu_pkg::byte_t src[$]);
    for (int i = 0; i < src.size(); i++) send_byte(src[i], i == src.size() - 1);
    sources_sent++;
  endtask

  task automatic send_text(input string s);
    issu_pkg::byte_t src[$];
    for (int i = 0; i < s.len(); i++) src.push_back(issu_pkg::byte_t'(s[i]));
    send_source(src);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic issu_pkg::byte_t random_letter();
    issu_pkg::byte_t base;
    base = $urandom_range(0, 1) ? "A" : "a";
    return base + issu_pkg::byte_t'($urandom_range(0, 25));
  endfunction

  // append one random token of script source
  task automatic add_token(ref issu_pkg::byte_t src[$]);
    string           run_chars;
    string           marks;
    int              pick;
    int              n;
    issu_pkg::byte_t q;
    run_chars = "0123456789_xabcdfABCDF";
    marks     = ".eEpP";
    pick      = $urandom_range(0, 99);
    if (pick < 20) begin
      // identifier
      n = $urandom_range(1, 5);
      repeat (n) src.push_back(random_letter());
    end else if (pick < 35) begin
      // numeric run, now and then a float literal
      src.push_back(issu_pkg::byte_t'("0") + issu_pkg::byte_t'($urandom_range(0, 9)));
      n = $urandom_range(0, 3);
      repeat (n)
        src.push_back(issu_pkg::byte_t'(run_chars[$urandom_range(0, run_chars.len() - 1)]));
      if ($urandom_range(0, 7) == 0) begin
        src.push_back(issu_pkg::byte_t'(marks[$urandom_range(0, marks.len() - 1)]));
        src.push_back(issu_pkg::byte_t'("0") + issu_pkg::byte_t'($urandom_range(0, 9)));
      end
    end else if (pick < 50) begin
      // quoted string with escapes and newlines
      q = $urandom_range(0, 1) ? issu_pkg::CH_DQUOTE : issu_pkg::CH_SQUOTE;
      src.push_back(q);
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: src.push_back(random_letter());
          1: src.push_back((q == issu_pkg::CH_DQUOTE) ? issu_pkg::CH_SQUOTE :
                                                        issu_pkg::CH_DQUOTE);
          2: begin
            src.push_back(issu_pkg::CH_BSLASH);
            src.push_back(issu_pkg::byte_t'($urandom_range(0, 255)));
          end
          3: src.push_back(issu_pkg::CH_NL);
          4: src.push_back(" ");
          default: begin
            src.push_back(issu_pkg::CH_BSLASH);
            src.push_back(issu_pkg::CH_NL);
          end
        endcase
      end
      if ($urandom_range(0, 19) != 0) src.push_back(q);
    end else if (pick < 60) begin
      // comment up to the newline
      src.push_back(issu_pkg::CH_DASH);
      src.push_back(issu_pkg::CH_DASH);
      n = $urandom_range(0, 4);
      repeat (n) src.push_back(issu_pkg::byte_t'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0) src.push_back(issu_pkg::CH_NL);
    end else if (pick < 70) begin
      src.push_back(issu_pkg::CH_NL);
    end else if (pick < 80) begin
      case ($urandom_range(0, 4))
        0: src.push_back(" ");
        1: src.push_back("+");
        2: src.push_back("(");
        3: src.push_back(")");
        default: src.push_back("=");
      endcase
    end else if (pick < 86) begin
      src.push_back(issu_pkg::CH_SLASH);
      src.push_back(issu_pkg::CH_SLASH);
    end else if (pick < 90) begin
      src.push_back(issu_pkg::CH_DASH);
      src.push_back(" ");
    end else if (pick < 92) begin
      src.push_back(issu_pkg::CH_CARET);
    end else if (pick < 94) begin
      src.push_back(issu_pkg::CH_SLASH);
      src.push_back(" ");
    end else begin
      src.push_back(issu_pkg::byte_t'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) == 0) src.push_back(" ");
  endtask

  // ---------------------------------------------------------------------------
  // output side: check each result transaction, then pick the next ready
  // ---------------------------------------------------------------------------
  initial begin
    issu_pkg::out_item_t exp_res;
    out_ch.ready       = 1'b0;
    hold_left          = 0;
    held_cycles        = 0;
    input_stall_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && in_ch.valid && !in_ch.ready) input_stall_cycles++;
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual error_kind %0d line %0d",
                   $time, out_ch.error_kind, out_ch.line_number);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch.error_kind !== exp_res.error_kind) begin
            $display("%0t: error_kind mismatch, expected %0d actual %0d",
                     $time, exp_res.error_kind, out_ch.error_kind);
            fail_count++;
          end
          if (out_ch.line_number !== exp_res.line_number) begin
            $display("%0t: line_number mismatch, expected %0d actual %0d",
                     $time, exp_res.line_number, out_ch.line_number);
            fail_count++;
          end
        end
      end
      // long hold-off when requested, else random gaps
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        held_cycles++;
        out_ch.ready <= 1'b0;
      end else if (gaps_on && ($urandom_range(0, 99) < 7)) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_count, expected_results.size());
    $display("FAIL integer_subset_source_scanner_unit");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    issu_pkg::byte_t src[$];
    gaps_on = 1'b1;
    // byte extremes as one-byte sources
    src = {8'h00};
    send_source(src);
    src = {8'hFF};
    send_source(src);
    // float literal, then the newline is dropped up to the end
    send_text("7.\n");
    // caret on the second line as the final byte
    send_text("a\n^");
    // backslash as the final byte leaves the string open
    send_text("'\\");
    // opening quote as the final byte
    send_text("\"");
    // double slash passes, dash as the final byte is plain text
    send_text("//-");
    // caret inside a comment is ignored, lone slash on line two
    send_text("--^\n/x");
    // hex-looking run holding an e
    send_text("0x1e");
    idle_input();
    wait_drained();
  endtask

  // all bytes sent count toward the target, dropped ones included
  task automatic test_random_traffic(input int target_bytes, input bit with_gaps);
    issu_pkg::byte_t src[$];
    int              start;
    int              n;
    gaps_on = with_gaps;
    start   = live_bytes + dropped_bytes;
    while (live_bytes + dropped_bytes - start < target_bytes) begin
      src = {};
      n   = $urandom_range(1, 8);
      repeat (n) add_token(src);
      send_source(src);
    end
    idle_input();
  endtask

  // hold the output off while short sources keep coming, then pause for all results
  task automatic test_output_hold();
    issu_pkg::byte_t src[$];
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (16) begin
      src = {};
      src.push_back($urandom_range(0, 1) ? issu_pkg::CH_NL : issu_pkg::byte_t'("a"));
      send_source(src);
    end
    idle_input();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    fail_count          = 0;
    sources_sent        = 0;
    live_bytes          = 0;
    dropped_bytes       = 0;
    gaps_on             = 1'b0;
    hold_req            = 1'b0;
    kind_count          = '{default: 0};
    in_ch.valid         = 1'b0;
    in_ch.source_byte   = '0;
    in_ch.end_of_source = 1'b0;
    rst_n               = 1'b0;
    reset_scanner();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic(180, 1'b1);
    test_output_hold();
    test_random_traffic(90, 1'b0);
    test_random_traffic(140, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("scanned %0d sources, %0d bytes (%0d more dropped after errors)",
             sources_sent, live_bytes, dropped_bytes);
    $display("ok %0d, open string %0d, slash %0d, caret %0d, float %0d; held %0d, stalled %0d",
             kind_count[issu_pkg::ERR_NONE], kind_count[issu_pkg::ERR_UNTERM],
             kind_count[issu_pkg::ERR_SLASH], kind_count[issu_pkg::ERR_CARET],
             kind_count[issu_pkg::ERR_FLOAT], held_cycles, input_stall_cycles);
    if (fail_count == 0) begin
      $display("PASS integer_subset_source_scanner_unit");
    end else begin
      $display("FAIL integer_subset_source_scanner_unit");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/issu_pkg.sv
rtl/issu_in_if.sv
rtl/issu_out_if.sv
rtl/integer_subset_source_scanner_unit.sv
tb/testbench.sv
